### hdl/particle_pool_spawn_and_tick_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the particle pool
// Checks written against clock, with reset disabling them.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_POOL_SPAWN_AND_TICK_MACROS_SVH
`define PARTICLE_POOL_SPAWN_AND_TICK_MACROS_SVH

// same-cycle implication
`define PPST_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the cycle after the antecedent
`define PPST_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/ppst_pkg.sv
// ----------------------------------------------------------------------------
// ppst_pkg
// Types, widths and codes shared by the particle pool modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ppst_pkg;

   localparam int SLOTS      = 32;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int CNT_W      = $clog2(SLOTS + 1);
   localparam int MAX_OUT    = 32;
   localparam int REP_W      = $clog2(MAX_OUT + 1);
   localparam int RSP_SLOT_W = 5;

   localparam int POS_W   = 24;
   localparam int SIZE_W  = 16;
   localparam int LIFE_W  = 17;
   localparam int ALPHA_W = 8;
   localparam int DT_W    = 16;
   localparam int FRAC_W  = 8;
   localparam int PROD_W  = POS_W + DT_W + 1;

   localparam int FADE_RATE = 200;

   localparam logic CMD_SPAWN   = 1'b0;
   localparam logic CMD_TICK    = 1'b1;
   localparam logic REPLY_SPAWN = 1'b0;
   localparam logic REPLY_TICK  = 1'b1;
   localparam logic KIND_PLAIN  = 1'b0;
   localparam logic KIND_IMPACT = 1'b1;

   typedef struct packed {
      logic                    cmd;
      logic signed [POS_W-1:0] start_x;
      logic signed [POS_W-1:0] start_y;
      logic signed [POS_W-1:0] speed_x;
      logic signed [POS_W-1:0] speed_y;
      logic                    effect_kind;
      logic [7:0]              start_size;
      logic [15:0]             start_life;
      logic [ALPHA_W-1:0]      start_alpha;
      logic [DT_W-1:0]         step_dt;
   } ppst_req_type;

   typedef struct packed {
      logic                     reply_kind;
      logic [RSP_SLOT_W-1:0]    slot;
      logic                     accepted;
      logic signed [POS_W-1:0]  cur_x;
      logic signed [POS_W-1:0]  cur_y;
      logic signed [SIZE_W-1:0] cur_size;
      logic [ALPHA_W-1:0]       cur_alpha;
      logic                     cur_kind;
      logic                     last;
   } ppst_rsp_type;

   // one pool entry as held in the slot memory
   typedef struct packed {
      logic                     kind;
      logic signed [POS_W-1:0]  posx;
      logic signed [POS_W-1:0]  posy;
      logic signed [POS_W-1:0]  velx;
      logic signed [POS_W-1:0]  vely;
      logic signed [SIZE_W-1:0] size;
      logic signed [LIFE_W-1:0] life;
      logic [ALPHA_W-1:0]       alpha;
   } ppst_rec_type;

endpackage

`default_nettype wire

### hdl/ppst_upd.sv
// ----------------------------------------------------------------------------
// ppst_upd
// One time step for a pool entry: position, lifetime, and for impact entries fade and shrink.
// ----------------------------------------------------------------------------
`default_nettype none

module ppst_upd (
   input  ppst_pkg::ppst_rec_type                rec_old,
   input  logic signed [ppst_pkg::PROD_W-1:0]    prod_x,
   input  logic signed [ppst_pkg::PROD_W-1:0]    prod_y,
   input  logic [ppst_pkg::DT_W-1:0]             dt,
   output ppst_pkg::ppst_rec_type                rec_new,
   output logic                                  keep
);
   import ppst_pkg::*;

   localparam int STEP_W = PROD_W - FRAC_W;
   localparam int SUM_W  = STEP_W + 1;
   localparam int LV_W   = LIFE_W + FRAC_W + 1;
   localparam int SV_W   = SIZE_W + FRAC_W + 1;
   localparam int FD_W   = ALPHA_W + DT_W;
   localparam int AV_W   = FD_W + 1;

   localparam logic [FRAC_W-1:0] FRAC_MASK = {FRAC_W{1'b1}};

   localparam logic signed [POS_W-1:0]  POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0]  POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic signed [LIFE_W-1:0] LIFE_MAX = {1'b0, {(LIFE_W-1){1'b1}}};
   localparam logic signed [LIFE_W-1:0] LIFE_MIN = {1'b1, {(LIFE_W-1){1'b0}}};
   localparam logic signed [SIZE_W-1:0] SIZE_MAX = {1'b0, {(SIZE_W-1){1'b1}}};
   localparam logic signed [SIZE_W-1:0] SIZE_MIN = {1'b1, {(SIZE_W-1){1'b0}}};

   logic signed [STEP_W-1:0] step_x, step_y;
   logic signed [SUM_W-1:0]  sum_x, sum_y;
   logic signed [LV_W-1:0]   lv, lv_adj;
   logic signed [LV_W-FRAC_W-1:0] lq;
   logic signed [SV_W-1:0]   sv, sv_adj;
   logic signed [SV_W-FRAC_W-1:0] sq;
   logic [FD_W-1:0]          fade_dt;
   logic [AV_W-1:0]          av;

   always_comb begin
      // floor division by 256 is the arithmetic shift
      step_x = prod_x[PROD_W-1:FRAC_W];
      step_y = prod_y[PROD_W-1:FRAC_W];
      sum_x  = SUM_W'(rec_old.posx) + SUM_W'(step_x);
      sum_y  = SUM_W'(rec_old.posy) + SUM_W'(step_y);

      // truncation toward zero: bias negatives before the shift
      lv     = LV_W'($signed({rec_old.life, {FRAC_W{1'b0}}})) - LV_W'(dt);
      lv_adj = lv[LV_W-1] ? lv + LV_W'(FRAC_MASK) : lv;
      lq     = lv_adj[LV_W-1:FRAC_W];

      sv     = SV_W'($signed({rec_old.size, {FRAC_W{1'b0}}})) - SV_W'(dt);
      sv_adj = sv[SV_W-1] ? sv + SV_W'(FRAC_MASK) : sv;
      sq     = sv_adj[SV_W-1:FRAC_W];

      fade_dt = FD_W'(FADE_RATE) * FD_W'(dt);
      av      = AV_W'({rec_old.alpha, {FRAC_W{1'b0}}}) - AV_W'(fade_dt);

      rec_new = rec_old;

      if (sum_x > POS_MAX)      rec_new.posx = POS_MAX;
      else if (sum_x < POS_MIN) rec_new.posx = POS_MIN;
      else                      rec_new.posx = sum_x[POS_W-1:0];

      if (sum_y > POS_MAX)      rec_new.posy = POS_MAX;
      else if (sum_y < POS_MIN) rec_new.posy = POS_MIN;
      else                      rec_new.posy = sum_y[POS_W-1:0];

      if (lq > LIFE_MAX)      rec_new.life = LIFE_MAX;
      else if (lq < LIFE_MIN) rec_new.life = LIFE_MIN;
      else                    rec_new.life = lq[LIFE_W-1:0];

      if (rec_old.kind == KIND_IMPACT) begin
         if (av[AV_W-1] || av == '0) rec_new.alpha = '0;
         else                        rec_new.alpha = av[FRAC_W+ALPHA_W-1:FRAC_W];

         if (sq > SIZE_MAX)      rec_new.size = SIZE_MAX;
         else if (sq < SIZE_MIN) rec_new.size = SIZE_MIN;
         else                    rec_new.size = sq[SIZE_W-1:0];
      end

      // the entry stays active only if its lifetime was positive before the step
      keep = !rec_old.life[LIFE_W-1] && (rec_old.life != '0);
   end

endmodule

`default_nettype wire

### hdl/particle_pool_spawn_and_tick.sv
// ----------------------------------------------------------------------------
// particle_pool_spawn_and_tick: a spawn's reply is registered, valid in the next cycle.
// Tick holds busy for the whole sweep: one slot memory read per cycle, 3-deep pipe.
// Each tick report is held until the next one is found; the last one appears as busy drops.
// Synchronous reset empties the pool (all slots inactive) and returns to idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "particle_pool_spawn_and_tick_macros.svh"

module particle_pool_spawn_and_tick (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ppst_pkg::ppst_req_type req_item,
   output logic                   rsp_valid,
   output ppst_pkg::ppst_rsp_type rsp_item
);
   import ppst_pkg::*;

   typedef enum logic {ST_IDLE, ST_SWEEP} state_type;

   state_type               state_ff, state_in;
   logic [SLOTS-1:0]        live_ff, live_in;
   logic [CNT_W-1:0]        rd_idx_ff, rd_idx_in;
   logic [DT_W-1:0]         dt_ff, dt_in;
   logic                    s1_v_ff, s1_v_in;
   logic                    s1_live_ff, s1_live_in;
   logic [SLOT_W-1:0]       s1_idx_ff, s1_idx_in;
   logic                    s2_v_ff, s2_v_in;
   logic                    s2_live_ff, s2_live_in;
   logic [SLOT_W-1:0]       s2_idx_ff, s2_idx_in;
   ppst_rec_type            s2_rec_ff, s2_rec_in;
   logic signed [PROD_W-1:0] s2_px_ff, s2_px_in;
   logic signed [PROD_W-1:0] s2_py_ff, s2_py_in;
   logic                    pend_v_ff, pend_v_in;
   ppst_rsp_type            pend_ff, pend_in;
   logic [REP_W-1:0]        rep_cnt_ff, rep_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   ppst_rsp_type            rsp_ff, rsp_in;

   ppst_rec_type            pool_mem_ff [SLOTS];
   ppst_rec_type            rd_rec_ff;

   logic [SLOT_W-1:0]       rd_addr;
   logic                    free_found;
   logic [SLOT_W-1:0]       free_idx;
   logic                    accept;
   logic                    spawn_wr;
   logic                    s2_act;
   logic                    report;
   logic                    upd_keep;
   ppst_rec_type            upd_rec;
   ppst_rec_type            spawn_rec;
   logic                    mem_we;
   logic [SLOT_W-1:0]       mem_waddr;
   ppst_rec_type            mem_wdata;

   ppst_upd u_upd (
      .rec_old (s2_rec_ff),
      .prod_x  (s2_px_ff),
      .prod_y  (s2_py_ff),
      .dt      (dt_ff),
      .rec_new (upd_rec),
      .keep    (upd_keep)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign accept    = start && !busy;
   assign rd_addr   = rd_idx_ff[SLOT_W-1:0];
   assign spawn_wr  = accept && (req_item.cmd == CMD_SPAWN) && free_found;
   assign s2_act    = s2_v_ff && s2_live_ff;
   assign report    = s2_act && upd_keep && (rep_cnt_ff < REP_W'(MAX_OUT));

   // lowest numbered free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      spawn_rec.kind  = req_item.effect_kind;
      spawn_rec.posx  = req_item.start_x;
      spawn_rec.posy  = req_item.start_y;
      spawn_rec.velx  = req_item.speed_x;
      spawn_rec.vely  = req_item.speed_y;
      spawn_rec.size  = SIZE_W'(req_item.start_size);
      spawn_rec.life  = LIFE_W'(req_item.start_life);
      spawn_rec.alpha = req_item.start_alpha;
   end

   // single write port: spawn writes only while idle, writeback only while sweeping
   always_comb begin
      mem_we    = spawn_wr || s2_act;
      mem_waddr = s2_act ? s2_idx_ff : free_idx;
      mem_wdata = s2_act ? upd_rec : spawn_rec;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pool_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_rec_ff <= pool_mem_ff[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      live_in      = live_ff;
      rd_idx_in    = rd_idx_ff;
      dt_in        = dt_ff;
      s1_v_in      = 1'b0;
      s1_idx_in    = rd_addr;
      s1_live_in   = live_ff[rd_addr];
      s2_v_in      = s1_v_ff;
      s2_idx_in    = s1_idx_ff;
      s2_live_in   = s1_live_ff;
      s2_rec_in    = rd_rec_ff;
      s2_px_in     = $signed(rd_rec_ff.velx) * $signed({1'b0, dt_ff});
      s2_py_in     = $signed(rd_rec_ff.vely) * $signed({1'b0, dt_ff});
      pend_v_in    = pend_v_ff;
      pend_in      = pend_ff;
      rep_cnt_in   = rep_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.cmd == CMD_TICK) begin
                  state_in   = ST_SWEEP;
                  rd_idx_in  = '0;
                  dt_in      = req_item.step_dt;
                  rep_cnt_in = '0;
                  pend_v_in  = 1'b0;
               end else begin
                  rsp_valid_in       = 1'b1;
                  rsp_in             = '0;
                  rsp_in.reply_kind  = REPLY_SPAWN;
                  rsp_in.last        = 1'b1;
                  if (free_found) begin
                     live_in[free_idx] = 1'b1;
                     rsp_in.slot       = RSP_SLOT_W'(free_idx);
                     rsp_in.accepted   = 1'b1;
                     rsp_in.cur_x      = spawn_rec.posx;
                     rsp_in.cur_y      = spawn_rec.posy;
                     rsp_in.cur_size   = spawn_rec.size;
                     rsp_in.cur_alpha  = spawn_rec.alpha;
                     rsp_in.cur_kind   = spawn_rec.kind;
                  end
               end
            end
         end
         ST_SWEEP: begin
            if (rd_idx_ff < CNT_W'(SLOTS)) begin
               s1_v_in   = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (s2_act && !upd_keep) begin
               live_in[s2_idx_ff] = 1'b0;
            end
            // hold each report back one place so the final one can carry last
            if (report) begin
               rep_cnt_in         = rep_cnt_ff + 1'b1;
               pend_v_in          = 1'b1;
               pend_in.reply_kind = REPLY_TICK;
               pend_in.slot       = RSP_SLOT_W'(s2_idx_ff);
               pend_in.accepted   = 1'b0;
               pend_in.cur_x      = upd_rec.posx;
               pend_in.cur_y      = upd_rec.posy;
               pend_in.cur_size   = upd_rec.size;
               pend_in.cur_alpha  = upd_rec.alpha;
               pend_in.cur_kind   = upd_rec.kind;
               pend_in.last       = 1'b0;
               if (pend_v_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = pend_ff;
               end
            end
            if (rd_idx_ff == CNT_W'(SLOTS) && !s1_v_ff && !s2_v_ff) begin
               state_in  = ST_IDLE;
               pend_v_in = 1'b0;
               if (pend_v_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = pend_ff;
                  rsp_in.last  = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_idx_in;
      dt_ff      <= dt_in;
      s1_idx_ff  <= s1_idx_in;
      s1_live_ff <= s1_live_in;
      s2_idx_ff  <= s2_idx_in;
      s2_live_ff <= s2_live_in;
      s2_rec_ff  <= s2_rec_in;
      s2_px_ff   <= s2_px_in;
      s2_py_ff   <= s2_py_in;
      pend_ff    <= pend_in;
      rep_cnt_ff <= rep_cnt_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `PPST_ASSERT_NEXT(a_spawn_reply, start && !busy && req_item.cmd == CMD_SPAWN, rsp_valid && rsp_item.reply_kind == REPLY_SPAWN && rsp_item.last, "spawn item without its reply")
   `PPST_ASSERT_NOW(a_pipe_distinct, s1_v_ff && s2_v_ff, s1_idx_ff != s2_idx_ff, "same slot in two pipe stages")
   `PPST_ASSERT_NOW(a_tick_last_idle, rsp_valid && rsp_item.reply_kind == REPLY_TICK && rsp_item.last, !busy, "final tick report while still busy")
   `PPST_ASSERT_NOW(a_tick_mid_busy, rsp_valid && rsp_item.reply_kind == REPLY_TICK && !rsp_item.last, busy, "tick report after sweep end")

endmodule

`default_nettype wire

### test/particle_pool_spawn_and_tick_tb.sv
// ----------------------------------------------------------------------------
// particle_pool_spawn_and_tick_tb
// Drives spawn and tick items into the particle pool and compares every
// reply and tick report, field by field, with a behavioral copy of the pool.
// A short table of hand-picked items comes first, then a long saturating run,
// then random bursts of spawns and ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_pool_spawn_and_tick_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import ppst_pkg::*;

   localparam int ITEMS      = 420;
   localparam int QUIET_TAIL = 60;
   localparam int STALL_MAX  = 3000;
   localparam int DRAIN_WAIT = 40;
   localparam int REQ_BITS   = $bits(ppst_req_type);

   typedef struct {
      ppst_req_type item;
      bit           fixed;
      ppst_rsp_type want;
   } script_row_type;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   ppst_req_type req_item = '0;
   logic         busy;
   logic         rsp_valid;
   ppst_rsp_type rsp_item;

   // behavioral copy of the pool
   bit                       pool_live  [SLOTS];
   logic                     pool_kind  [SLOTS];
   logic signed [POS_W-1:0]  pool_px    [SLOTS];
   logic signed [POS_W-1:0]  pool_py    [SLOTS];
   logic signed [POS_W-1:0]  pool_vx    [SLOTS];
   logic signed [POS_W-1:0]  pool_vy    [SLOTS];
   logic signed [SIZE_W-1:0] pool_size  [SLOTS];
   logic signed [LIFE_W-1:0] pool_life  [SLOTS];
   logic [ALPHA_W-1:0]       pool_alpha [SLOTS];

   ppst_rsp_type   step_reports[$];
   ppst_rsp_type   due_reports[$];
   script_row_type script[$];
   int           sent       = 0;
   int           errors     = 0;
   int           stall_cnt  = 0;

   particle_pool_spawn_and_tick DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp_signed(input longint v, input int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic void pool_clear();
      for (int i = 0; i < SLOTS; i++) begin
         pool_live[i]  = 1'b0;
         pool_kind[i]  = KIND_PLAIN;
         pool_px[i]    = '0;
         pool_py[i]    = '0;
         pool_vx[i]    = '0;
         pool_vy[i]    = '0;
         pool_size[i]  = '0;
         pool_life[i]  = '0;
         pool_alpha[i] = 8'hFF;
      end
   endfunction

   // applies one item to the pool copy and leaves its results in step_reports
   function automatic void advance_pool(input ppst_req_type it);
      ppst_rsp_type r;
      longint       dt;
      longint       fade;
      bit           placed;
      int           n;
      step_reports.delete();
      if (it.cmd == CMD_SPAWN) begin
         r = '0;
         r.reply_kind = REPLY_SPAWN;
         r.last = 1'b1;
         placed = 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            if (!placed && !pool_live[i]) begin
               placed        = 1'b1;
               pool_live[i]  = 1'b1;
               pool_px[i]    = it.start_x;
               pool_py[i]    = it.start_y;
               pool_vx[i]    = it.speed_x;
               pool_vy[i]    = it.speed_y;
               pool_kind[i]  = it.effect_kind;
               pool_size[i]  = {8'b0, it.start_size};
               pool_life[i]  = {1'b0, it.start_life};
               pool_alpha[i] = it.start_alpha;
               r.slot      = i[RSP_SLOT_W-1:0];
               r.accepted  = 1'b1;
               r.cur_x     = pool_px[i];
               r.cur_y     = pool_py[i];
               r.cur_size  = pool_size[i];
               r.cur_alpha = pool_alpha[i];
               r.cur_kind  = pool_kind[i];
            end
         end
         step_reports.push_back(r);
      end else begin
         dt = longint'(it.step_dt);
         n = 0;
         for (int i = 0; i < SLOTS; i++) begin
            if (pool_live[i]) begin
               // retired slots still take this step's update
               if (pool_life[i] <= 0) pool_live[i] = 1'b0;
               pool_px[i] = POS_W'(clamp_signed(longint'(pool_px[i]) +
                                   ((longint'(pool_vx[i]) * dt) >>> FRAC_W), POS_W));
               pool_py[i] = POS_W'(clamp_signed(longint'(pool_py[i]) +
                                   ((longint'(pool_vy[i]) * dt) >>> FRAC_W), POS_W));
               pool_life[i] = LIFE_W'(clamp_signed((longint'(pool_life[i]) * 256 - dt) / 256,
                                                   LIFE_W));
               if (pool_kind[i] == KIND_IMPACT) begin
                  fade = longint'(pool_alpha[i]) * 256 - FADE_RATE * dt;
                  pool_alpha[i] = ALPHA_W'((fade > 0) ? fade / 256 : longint'(0));
                  pool_size[i] = SIZE_W'(clamp_signed((longint'(pool_size[i]) * 256 - dt) / 256,
                                                      SIZE_W));
               end
               if (pool_live[i] && n < MAX_OUT) begin
                  r = '0;
                  r.reply_kind = REPLY_TICK;
                  r.slot       = i[RSP_SLOT_W-1:0];
                  r.cur_x      = pool_px[i];
                  r.cur_y      = pool_py[i];
                  r.cur_size   = pool_size[i];
                  r.cur_alpha  = pool_alpha[i];
                  r.cur_kind   = pool_kind[i];
                  step_reports.push_back(r);
                  n++;
               end
            end
         end
         if (n > 0) step_reports[n-1].last = 1'b1;
      end
   endfunction

   function automatic ppst_req_type spawn_req(input logic [23:0] x, y, vx, vy,
                                              input logic kind, input logic [7:0] size,
                                              input logic [15:0] life, input logic [7:0] alpha);
      ppst_req_type it;
      it.cmd         = CMD_SPAWN;
      it.start_x     = x;
      it.start_y     = y;
      it.speed_x     = vx;
      it.speed_y     = vy;
      it.effect_kind = kind;
      it.start_size  = size;
      it.start_life  = life;
      it.start_alpha = alpha;
      it.step_dt     = 16'hFFFF;   // ignored by a spawn
      return it;
   endfunction

   function automatic ppst_req_type tick_req(input logic [15:0] dt);
      ppst_req_type it;
      it = '1;                     // spawn fields are ignored by a tick
      it.cmd     = CMD_TICK;
      it.step_dt = dt;
      return it;
   endfunction

   function automatic ppst_rsp_type spawn_reply(input int slot, input logic [23:0] x, y,
                                                input logic [15:0] size,
                                                input logic [7:0] alpha, input logic kind);
      ppst_rsp_type r;
      r.reply_kind = REPLY_SPAWN;
      r.slot       = slot[RSP_SLOT_W-1:0];
      r.accepted   = 1'b1;
      r.cur_x      = x;
      r.cur_y      = y;
      r.cur_size   = size;
      r.cur_alpha  = alpha;
      r.cur_kind   = kind;
      r.last       = 1'b1;
      return r;
   endfunction

   function automatic void add_row(input ppst_req_type it, input bit fixed,
                                   input ppst_rsp_type want);
      script_row_type row;
      row.item  = it;
      row.fixed = fixed;
      row.want  = want;
      script.push_back(row);
   endfunction

   function automatic logic [23:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2, 3: return 24'($urandom_range(0, 4095) - 2048);
         default: return 24'($urandom());
      endcase
   endfunction

   function automatic logic [15:0] pick_life();
      case ($urandom_range(0, 9))
         7, 8: return 16'($urandom_range(0, 2000));
         9: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom_range(0, 6));
      endcase
   endfunction

   function automatic logic [15:0] pick_dt();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2, 3: return 16'($urandom_range(0, 16'h03FF));
         4, 5: return 16'($urandom_range(0, 16'h4000));
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic ppst_req_type random_req(input logic cmd);
      ppst_req_type it;
      it = ppst_req_type'(REQ_BITS'({$urandom(), $urandom(), $urandom(), $urandom(),
                                     $urandom()}));
      it.cmd = cmd;
      if (cmd == CMD_SPAWN) begin
         it.start_x    = pick_coord();
         it.start_y    = pick_coord();
         it.speed_x    = pick_coord();
         it.speed_y    = pick_coord();
         it.start_life = pick_life();
      end else begin
         it.step_dt = pick_dt();
      end
      return it;
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   // holds the item until accepted, then books its expected results
   task automatic send_item(input ppst_req_type it, input bit fixed,
                            input ppst_rsp_type want);
      @(negedge clock);
      start    <= 1'b1;
      req_item <= it;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sent++;
      advance_pool(it);
      if (fixed) due_reports.push_back(want);
      else foreach (step_reports[k]) due_reports.push_back(step_reports[k]);
   endtask

   task automatic idle_for(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start    <= 1'b0;
         req_item <= random_req(1'($urandom_range(0, 1)));
      end
   endtask

   task automatic maybe_idle();
      if (sent < ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
         idle_for($urandom_range(1, 13));
   endtask

   always @(posedge clock) begin
      ppst_rsp_type want;
      if (!reset && rsp_valid) begin
         if (due_reports.size() == 0) begin
            flag_mismatch($sformatf("unexpected result %h", rsp_item));
         end else begin
            want = due_reports.pop_front();
            check_field("reply_kind", 32'(rsp_item.reply_kind), 32'(want.reply_kind));
            check_field("slot",       32'(rsp_item.slot),       32'(want.slot));
            check_field("accepted",   32'(rsp_item.accepted),   32'(want.accepted));
            check_field("cur_x",      32'(rsp_item.cur_x),      32'(want.cur_x));
            check_field("cur_y",      32'(rsp_item.cur_y),      32'(want.cur_y));
            check_field("cur_size",   32'(rsp_item.cur_size),   32'(want.cur_size));
            check_field("cur_alpha",  32'(rsp_item.cur_alpha),  32'(want.cur_alpha));
            check_field("cur_kind",   32'(rsp_item.cur_kind),   32'(want.cur_kind));
            check_field("last",       32'(rsp_item.last),       32'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_MAX) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      ppst_rsp_type none;
      int           burst;
      bit           paused;
      none   = '0;
      paused = 1'b0;
      pool_clear();
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // tick on an empty pool: no result
      add_row(tick_req(16'h1234), 1'b0, none);
      add_row(spawn_req(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, KIND_IMPACT,
                        8'hFF, 16'hFFFF, 8'hFF), 1'b1,
              spawn_reply(0, 24'h7FFFFF, 24'h800000, 16'd255, 8'hFF, KIND_IMPACT));
      // zero lifetime: retired on the next tick, never reported
      add_row(spawn_req(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, KIND_PLAIN,
                        8'h00, 16'h0000, 8'h00), 1'b1,
              spawn_reply(1, 24'h800000, 24'h7FFFFF, 16'd0, 8'h00, KIND_PLAIN));
      add_row(spawn_req(24'h000100, 24'hFFFF00, 24'h000180, 24'hFFFF80, KIND_IMPACT,
                        8'd10, 16'd1, 8'd200), 1'b1,
              spawn_reply(2, 24'h000100, 24'hFFFF00, 16'd10, 8'd200, KIND_IMPACT));
      add_row(tick_req(16'h0000), 1'b0, none);
      add_row(tick_req(16'hFFFF), 1'b0, none);
      // slot 1 was freed by the first tick after its spawn
      add_row(spawn_req(24'h000000, 24'h000000, 24'h000001, 24'hFFFFFF, KIND_PLAIN,
                        8'd5, 16'd3, 8'd128), 1'b1,
              spawn_reply(1, 24'h000000, 24'h000000, 16'd5, 8'd128, KIND_PLAIN));
      add_row(tick_req(16'h0100), 1'b0, none);
      add_row(tick_req(16'h0001), 1'b0, none);
      add_row(spawn_req(24'h123456, 24'hEDCBA9, 24'hFFF000, 24'h001000, KIND_IMPACT,
                        8'd1, 16'd4, 8'd1), 1'b1,
              spawn_reply(2, 24'h123456, 24'hEDCBA9, 16'd1, 8'd1, KIND_IMPACT));
      add_row(tick_req(16'h00FF), 1'b0, none);
      add_row(tick_req(16'h8000), 1'b0, none);
      // slot 1 ran out of lifetime and was retired by the last tick
      add_row(spawn_req(24'h400000, 24'hC00000, 24'h7FFFFF, 24'h000000, KIND_IMPACT,
                        8'd0, 16'd2, 8'd0), 1'b1,
              spawn_reply(1, 24'h400000, 24'hC00000, 16'd0, 8'd0, KIND_IMPACT));
      add_row(tick_req(16'h0180), 1'b0, none);
      add_row(tick_req(16'hFFFF), 1'b0, none);

      foreach (script[i]) begin
         send_item(script[i].item, script[i].fixed, script[i].want);
         maybe_idle();
      end

      // long run of large steps: slot 0 shrinks until its size saturates
      send_item(spawn_req(pick_coord(), pick_coord(), 24'($urandom_range(0, 255)),
                          24'($urandom_range(0, 255)), KIND_IMPACT, 8'hFF, 16'hFFFF, 8'hFF),
                1'b0, none);
      repeat (135) begin
         send_item(tick_req(16'($urandom_range(16'hF000, 16'hFFFF))), 1'b0, none);
         maybe_idle();
      end

      while (sent < ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               // up to a little more than the pool holds, so drops happen
               burst = $urandom_range(1, SLOTS + 2);
               repeat (burst) begin
                  send_item(random_req(CMD_SPAWN), 1'b0, none);
                  maybe_idle();
               end
            end
            4, 5, 6, 7, 8: begin
               burst = $urandom_range(1, 8);
               repeat (burst) begin
                  send_item(random_req(CMD_TICK), 1'b0, none);
                  maybe_idle();
               end
            end
            default: begin
               burst = $urandom_range(1, 10);
               repeat (burst) begin
                  send_item(random_req(1'($urandom_range(0, 1))), 1'b0, none);
                  maybe_idle();
               end
            end
         endcase
         if (!paused && sent >= 280) begin
            paused = 1'b1;
            @(negedge clock);
            start <= 1'b0;
            while (due_reports.size() != 0) @(posedge clock);
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
